@@ rtl/plp_pkg.sv @@
`default_nettype none
package plp_pkg;
	localparam int HistDepthDef = 21;
	localparam logic [30:0] GravReset = 31'd642252;
	localparam logic [31:0] FloorReset = 32'd0;
	localparam logic CfgGravity = 1'b0;
	localparam logic CfgFloor = 1'b1;

	typedef struct packed {
		logic        first;
		logic        full;
		logic [31:0] t_cur;
		logic [31:0] t_prv;
		logic [31:0] t_old;
		logic [95:0] p_cur;
		logic [95:0] p_prv;
		logic [95:0] p_old;
	} job_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		logic signed [31:0] r;
		if (v > 66'sh7FFFFFFF) r = 32'sh7FFFFFFF;
		else if (v < -66'sh80000000) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction
endpackage
`default_nettype wire

@@ rtl/plp_div.sv @@
`default_nettype none
module plp_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] num,
	input  wire logic [31:0] den,
	output logic             done,
	output logic [63:0]      quo
);
	logic [63:0] n_q;
	logic [32:0] r_q;
	logic [31:0] d_q;
	logic [6:0]  cnt_q;
	logic [32:0] rs;
	always_comb rs = {r_q[31:0], n_q[63]};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				cnt_q <= 7'd64;
			end else if (cnt_q != 0) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) done <= 1'b1;
			end
		end
	end
	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			r_q <= '0;
			d_q <= den;
		end else if (cnt_q != 0) begin
			if (rs >= {1'b0, d_q}) begin
				r_q <= rs - {1'b0, d_q};
				n_q <= {n_q[62:0], 1'b1};
			end else begin
				r_q <= rs;
				n_q <= {n_q[62:0], 1'b0};
			end
		end
	end
	assign quo = n_q;
endmodule
`default_nettype wire

@@ rtl/plp_front.sv @@
`default_nettype none
module plp_front #(
	parameter int HIST_DEPTH = plp_pkg::HistDepthDef
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [31:0]          sample_time,
	input  wire logic signed [31:0]   pos_x,
	input  wire logic signed [31:0]   pos_y,
	input  wire logic signed [31:0]   pos_z,
	output logic                      job_valid,
	input  wire logic                 job_take,
	output plp_pkg::job_t             job
);
	import plp_pkg::*;
	localparam int PW = $clog2(HIST_DEPTH);
	localparam int CW = $clog2(HIST_DEPTH + 2);
	localparam logic [PW-1:0] LAST = PW'(HIST_DEPTH - 1);

	logic [31:0] tmem [HIST_DEPTH];
	logic [95:0] pmem [HIST_DEPTH];
	logic [PW-1:0] wp_q, prv, old;
	logic [CW-1:0] cnt_q, cnt_n;
	logic [1:0] ph_q;
	logic [31:0] t_in_q;
	logic [95:0] p_in_q;
	logic [31:0] t_rd_q;
	logic [95:0] p_rd_q;
	job_t jb_q;
	logic jv_q;

	assign prv = (wp_q == 0) ? LAST : wp_q - PW'(1);
	assign old = (wp_q == LAST) ? '0 : wp_q + PW'(1);
	assign cnt_n = (cnt_q < CW'(HIST_DEPTH + 1)) ? cnt_q + CW'(1) : cnt_q;
	assign in_stall = (ph_q != 2'd0) || jv_q;
	assign job_valid = jv_q;
	assign job = jb_q;

	always_ff @(posedge clk) begin
		if (ph_q == 2'd0 && in_valid && !in_stall) begin
			tmem[wp_q] <= sample_time;
			pmem[wp_q] <= {pos_x, pos_y, pos_z};
			t_in_q <= sample_time;
			p_in_q <= {pos_x, pos_y, pos_z};
		end
		t_rd_q <= tmem[(ph_q == 2'd1) ? prv : old];
		p_rd_q <= pmem[(ph_q == 2'd1) ? prv : old];
		if (ph_q == 2'd2) begin
			jb_q.t_prv <= t_rd_q;
			jb_q.p_prv <= p_rd_q;
		end
		if (ph_q == 2'd3) begin
			jb_q.t_old <= t_rd_q;
			jb_q.p_old <= p_rd_q;
			jb_q.t_cur <= t_in_q;
			jb_q.p_cur <= p_in_q;
			jb_q.first <= cnt_q < CW'(2);
			jb_q.full <= cnt_q > CW'(HIST_DEPTH);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			cnt_q <= '0;
			ph_q <= 2'd0;
			jv_q <= 1'b0;
		end else begin
			if (jv_q && job_take) jv_q <= 1'b0;
			unique case (ph_q)
				2'd0: if (in_valid && !in_stall) begin
					cnt_q <= cnt_n;
					ph_q <= 2'd1;
				end
				2'd1: ph_q <= 2'd2;
				2'd2: begin
					ph_q <= 2'd3;
					wp_q <= old;
				end
				default: begin
					ph_q <= 2'd0;
					jv_q <= 1'b1;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

@@ rtl/plp_back.sv @@
`default_nettype none
module plp_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                job_valid,
	output logic                     job_take,
	input  wire plp_pkg::job_t       job,
	input  wire logic [30:0]         grav,
	input  wire logic signed [31:0]  flr,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic                     landing_valid,
	output logic [31:0]              flight_time,
	output logic signed [31:0]       land_x,
	output logic signed [31:0]       land_y,
	output logic signed [31:0]       land_z
);
	import plp_pkg::*;
	localparam logic [4:0] S_IDLE = 5'd0, S_GAP = 5'd1, S_VEL = 5'd2, S_VWAIT = 5'd3,
		S_VSTO = 5'd4, S_BB = 5'd5, S_GC = 5'd6, S_D = 5'd7, S_SQ = 5'd8,
		S_R1 = 5'd9, S_R1W = 5'd10, S_R2 = 5'd11, S_R2W = 5'd12, S_SPAN = 5'd13,
		S_TT = 5'd14, S_A = 5'd15, S_G2 = 5'd16, S_VT = 5'd17, S_SUM = 5'd18,
		S_OUT = 5'd19, S_FAIL = 5'd20;

	logic [4:0] st_q;
	logic [1:0] ax_q;
	logic span_q;
	logic [31:0] gap_q;
	logic signed [31:0] v2_q [3];
	logic signed [31:0] vp_q [3];
	logic [63:0] bb_q, gc_q, s_q, acc_q;
	logic [31:0] t_q;
	logic [63:0] tt_q, a_q, gt_q;
	logic signed [65:0] land_q [3];
	logic [5:0] sq_cnt_q;
	logic [63:0] sr_q, sv_q;
	logic [32:0] dpos;
	logic dneg;
	logic div_start;
	logic [63:0] div_num;
	logic [31:0] div_den;
	logic div_done;
	logic [63:0] quo;
	logic signed [32:0] cpos;
	logic signed [31:0] cc;
	logic signed [31:0] b;
	logic signed [33:0] num1, num2;
	logic signed [31:0] pc [3];
	logic signed [31:0] pp [3];
	logic signed [31:0] po [3];
	logic signed [32:0] dsel;
	logic [63:0] vmag;
	logic ov;
	logic [31:0] vabs;
	logic [63:0] vtm;

	plp_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(div_den), .done(div_done), .quo(quo)
	);

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			pc[k] = job.p_cur[95-32*k -: 32];
			pp[k] = job.p_prv[95-32*k -: 32];
			po[k] = job.p_old[95-32*k -: 32];
		end
		dsel = span_q ? 33'(pp[ax_q]) - 33'(po[ax_q]) : 33'(pc[ax_q]) - 33'(pp[ax_q]);
		dneg = dsel < 0;
		dpos = dneg ? 33'(-dsel) : 33'(dsel);
		cpos = 33'(pc[1]) - 33'(flr);
		cc = sat32(66'(cpos));
		b = v2_q[1];
		num1 = 34'(b) - 34'(s_q);
		num2 = 34'(b) + 34'(s_q);
		vmag = quo;
		ov = dneg ? (vmag > 64'h80000000) : (vmag > 64'h7FFFFFFF);
		vabs = vp_q[ax_q] < 0 ? 32'(-33'(vp_q[ax_q])) : 32'(vp_q[ax_q]);
		vtm = 64'(vabs) * 64'(t_q);
		div_start = 1'b0;
		div_num = '0;
		div_den = gap_q;
		unique case (st_q)
			S_VEL: begin
				div_start = 1'b1;
				div_num = 64'(dpos[31:0]) * 64'd1000000;
				if (dpos[32]) div_num = 64'h80000000 * 64'd1000000;
			end
			S_R1: begin
				div_start = 1'b1;
				div_num = {14'd0, num1[33:0], 16'd0};
				div_den = {1'b0, grav};
			end
			S_R2: begin
				div_start = 1'b1;
				div_num = {14'd0, num2[33:0], 16'd0};
				div_den = {1'b0, grav};
			end
			default: ;
		endcase
	end

	assign job_take = (st_q == S_OUT || st_q == S_FAIL) && !(out_valid && out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			out_valid <= 1'b0;
			ax_q <= '0;
			span_q <= 1'b0;
		end else begin
			if (out_valid && !out_stall && !job_take) out_valid <= 1'b0;
			unique case (st_q)
				S_IDLE: if (job_valid) begin
					st_q <= job.first ? S_FAIL : S_GAP;
					span_q <= 1'b0;
				end
				S_GAP: begin
					ax_q <= '0;
					st_q <= (gap_q == 0 || grav == 0) ? S_FAIL : S_VEL;
				end
				S_VEL: st_q <= S_VWAIT;
				S_VWAIT: if (div_done) st_q <= S_VSTO;
				S_VSTO: begin
					if (ax_q == 2'd2) begin
						ax_q <= '0;
						st_q <= span_q ? S_TT : S_BB;
					end else begin
						ax_q <= ax_q + 2'd1;
						st_q <= S_VEL;
					end
				end
				S_BB: st_q <= S_GC;
				S_GC: st_q <= S_D;
				S_D: st_q <= (cc < 0 && bb_q < gc_q) ? S_FAIL : S_SQ;
				S_SQ: if (sq_cnt_q == 0) st_q <= S_R1;
				S_R1: st_q <= (num1 > 0) ? S_R1W : S_R2;
				S_R1W: if (div_done) st_q <= (quo == 0) ? S_R2 : S_SPAN;
				S_R2: st_q <= (num2 > 0) ? S_R2W : S_FAIL;
				S_R2W: if (div_done) st_q <= S_SPAN;
				S_SPAN: begin
					if (t_q == 0) st_q <= S_FAIL;
					else if (job.full) begin
						if (job.t_prv - job.t_old == 0) st_q <= S_FAIL;
						else begin
							span_q <= 1'b1;
							st_q <= S_VEL;
						end
					end else st_q <= S_TT;
				end
				S_TT: st_q <= S_A;
				S_A: st_q <= S_G2;
				S_G2: st_q <= S_VT;
				S_VT: begin
					if (ax_q == 2'd2) begin
						ax_q <= '0;
						st_q <= S_SUM;
					end else ax_q <= ax_q + 2'd1;
				end
				S_SUM: st_q <= S_OUT;
				default: if (!(out_valid && out_stall)) begin
					out_valid <= 1'b1;
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: gap_q <= job.t_cur - job.t_prv;
			S_VSTO: begin
				if (span_q)
					vp_q[ax_q] <= ov ? (dneg ? 32'sh80000000 : 32'sh7FFFFFFF)
						: (dneg ? 32'(-vmag[31:0]) : vmag[31:0]);
				else begin
					v2_q[ax_q] <= ov ? (dneg ? 32'sh80000000 : 32'sh7FFFFFFF)
						: (dneg ? 32'(-vmag[31:0]) : vmag[31:0]);
					vp_q[ax_q] <= ov ? (dneg ? 32'sh80000000 : 32'sh7FFFFFFF)
						: (dneg ? 32'(-vmag[31:0]) : vmag[31:0]);
				end
			end
			S_BB: begin
				acc_q <= {32'd0, (b < 0) ? 32'(-33'(b)) : 32'(b)};
				gc_q <= {32'd0, (cc < 0) ? 32'(-33'(cc)) : 32'(cc)};
			end
			S_GC: begin
				bb_q <= acc_q * acc_q;
				gc_q <= (64'(grav) * gc_q) << 1;
			end
			S_D: begin
				sv_q <= (cc >= 0) ? bb_q + gc_q : bb_q - gc_q;
				sr_q <= '0;
				sq_cnt_q <= 6'd32;
			end
			S_SQ: if (sq_cnt_q != 0) sq_cnt_q <= sq_cnt_q - 6'd1;
			S_R1W, S_R2W: if (div_done) t_q <= (quo > 64'hFFFFFFFF) ? 32'hFFFFFFFF : quo[31:0];
			S_SPAN: gap_q <= job.t_prv - job.t_old;
			S_TT: tt_q <= (64'(t_q) * 64'(t_q)) >> 16;
			S_A: a_q <= 64'(grav) * (tt_q >> 16);
			S_G2: gt_q <= (a_q >> 1) + ((((a_q & 64'd1) << 16) + 64'(grav) * (tt_q & 64'hFFFF)) >> 17);
			S_VT: land_q[ax_q] <= 66'(pc[ax_q]) + (vp_q[ax_q] < 0 ? -66'(vtm >> 16) : 66'(vtm >> 16));
			S_SUM: land_q[1] <= land_q[1] - 66'(gt_q);
			S_OUT: if (!(out_valid && out_stall)) begin
				landing_valid <= 1'b1;
				flight_time <= t_q;
				land_x <= sat32(land_q[0]);
				land_y <= sat32(land_q[1]);
				land_z <= sat32(land_q[2]);
			end
			S_FAIL: if (!(out_valid && out_stall)) begin
				landing_valid <= 1'b0;
				flight_time <= '0;
				land_x <= '0;
				land_y <= '0;
				land_z <= '0;
			end
			default: ;
		endcase
		if (st_q == S_SQ && sq_cnt_q != 0) begin
			if ({2'b00, sv_q} >= {2'b00, sr_q} + (66'd1 << (2 * (sq_cnt_q - 6'd1)))) begin
				sv_q <= sv_q - (sr_q + (64'd1 << (2 * (sq_cnt_q - 6'd1))));
				sr_q <= (sr_q >> 1) + (64'd1 << (2 * (sq_cnt_q - 6'd1)));
			end else sr_q <= sr_q >> 1;
		end
		if (st_q == S_SQ && sq_cnt_q == 0) s_q <= sr_q;
	end
endmodule
`default_nettype wire

@@ rtl/projectile_landing_predictor.sv @@
// Each request runs through the velocity divisions, a square root and one or two
// root divisions; once the history is full the span velocity adds a second set of
// velocity divisions, and rejected requests finish sooner. Each velocity axis is a
// 64-step division.
// The front end holds the next request off until the back end has taken the
// current one.
// Reset: arst_n clears control state and restores register defaults.
`default_nettype none
module projectile_landing_predictor #(
	parameter int HIST_DEPTH = plp_pkg::HistDepthDef
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic                cfg_index,
	input  wire logic [31:0]         cfg_data,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [31:0]         sample_time,
	input  wire logic signed [31:0]  pos_x,
	input  wire logic signed [31:0]  pos_y,
	input  wire logic signed [31:0]  pos_z,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic                     landing_valid,
	output logic [31:0]              flight_time,
	output logic signed [31:0]       land_x,
	output logic signed [31:0]       land_y,
	output logic signed [31:0]       land_z
);
	import plp_pkg::*;
	logic [30:0] grav_q;
	logic signed [31:0] flr_q;
	logic jv, jt;
	job_t jb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_q <= GravReset;
			flr_q <= FloorReset;
		end else if (cfg_we) begin
			if (cfg_index == CfgGravity) grav_q <= cfg_data[30:0];
			else flr_q <= cfg_data;
		end
	end

	plp_front #(.HIST_DEPTH(HIST_DEPTH)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.sample_time(sample_time), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.job_valid(jv), .job_take(jt), .job(jb)
	);

	plp_back u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(jv), .job_take(jt), .job(jb),
		.grav(grav_q), .flr(flr_q), .out_valid(out_valid), .out_stall(out_stall),
		.landing_valid(landing_valid), .flight_time(flight_time),
		.land_x(land_x), .land_y(land_y), .land_z(land_z)
	);
endmodule
`default_nettype wire

@@ rtl/plp_checker.sv @@
`default_nettype none
module plp_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic landing_valid,
	input wire logic [31:0] flight_time
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(flight_time)) else $error("hold");
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !landing_valid |-> flight_time == 0) else $error("zero");
	a_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && landing_valid |-> flight_time != 0) else $error("pos");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall) else $error("busy");
endmodule
bind projectile_landing_predictor plp_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall),
	.landing_valid(landing_valid), .flight_time(flight_time)
);
`default_nettype wire
